// ===== hdl/fixed_frame_header_tail_deframer_core_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the fixed-frame deframer
// Shared concurrent assertion forms, clocked and disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef FIXED_FRAME_HEADER_TAIL_DEFRAMER_CORE_DEFINES_SVH
`define FIXED_FRAME_HEADER_TAIL_DEFRAMER_CORE_DEFINES_SVH

// Same-cycle implication: cons must hold whenever ante holds.
`define FFHTD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deframer assertion failed");

// Next-cycle implication: cons must hold in the cycle after ante.
`define FFHTD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deframer assertion failed");

`endif

// ===== hdl/ffhtd_pkg.sv =====
// ----------------------------------------------------------------------------
// ffhtd_pkg
// Constants and types shared by the fixed-frame deframer modules.
// ----------------------------------------------------------------------------
package ffhtd_pkg;

    localparam int BYTE_W      = 8;
    localparam int IDX_W       = 6;
    localparam int STORE_DEPTH = 39;
    localparam int STORE_IDX_W = $clog2(STORE_DEPTH);

    localparam logic [BYTE_W-1:0] HEAD_FIRST  = 8'h5A;
    localparam logic [BYTE_W-1:0] HEAD_SECOND = 8'hA5;
    localparam logic [BYTE_W-1:0] TAIL_FIRST  = 8'h7F;
    localparam logic [BYTE_W-1:0] TAIL_SECOND = 8'hFE;

    // Frame offsets of the 43-byte frame
    localparam logic [IDX_W-1:0] IDX_STORE_FIRST = 6'd2;
    localparam logic [IDX_W-1:0] IDX_STORE_LAST  = 6'd40;
    localparam logic [IDX_W-1:0] IDX_TAIL_FIRST  = 6'd41;
    localparam logic [IDX_W-1:0] IDX_TAIL_SECOND = 6'd42;

    // First declared member sits in the highest bits, so aim_mode lands at bit 0
    typedef struct packed {
        logic [15:0] shot_count;
        logic [31:0] shot_speed_bits;
        logic [31:0] pitch_rate_bits;
        logic [31:0] pitch_bits;
        logic [31:0] yaw_rate_bits;
        logic [31:0] yaw_bits;
        logic [31:0] quat_z_bits;
        logic [31:0] quat_y_bits;
        logic [31:0] quat_x_bits;
        logic [31:0] quat_w_bits;
        logic [7:0]  aim_mode;
    } frame_payload_t;

    localparam int OUT_W = $bits(frame_payload_t);

    typedef struct packed {
        logic frame_good;  // accepted byte completes a frame with a good tail
        logic at_tail_end; // next collected byte is the second tail byte
    } framer_status_t;

endpackage

// ===== hdl/ffhtd_framer.sv =====
// ----------------------------------------------------------------------------
// ffhtd_framer
// Header hunt, frame collection, tail check and payload assembly.
// ----------------------------------------------------------------------------
module ffhtd_framer
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                byte_valid,
    input  logic [ffhtd_pkg::BYTE_W-1:0]        rx_byte,
    output ffhtd_pkg::framer_status_t           status,
    output ffhtd_pkg::frame_payload_t           payload
);

    logic                             collecting_reg;
    logic                             collecting_next;
    logic                             saw_head_reg;
    logic                             saw_head_next;
    logic                             tail_ok_reg;
    logic                             tail_ok_next;
    logic [ffhtd_pkg::IDX_W-1:0]      byte_index_reg;
    logic [ffhtd_pkg::IDX_W-1:0]      byte_index_next;
    logic                             store_wr;
    logic [ffhtd_pkg::IDX_W-1:0]      store_off;
    logic                             frame_good;
    logic [ffhtd_pkg::BYTE_W-1:0]     store_reg [0:ffhtd_pkg::STORE_DEPTH-1];

    assign store_off = byte_index_reg - ffhtd_pkg::IDX_STORE_FIRST;

    always_comb
    begin
        collecting_next = collecting_reg;
        saw_head_next   = saw_head_reg;
        tail_ok_next    = tail_ok_reg;
        byte_index_next = byte_index_reg;
        store_wr        = 1'b0;
        frame_good      = 1'b0;
        if (byte_valid)
        begin
            if (!collecting_reg)
            begin
                if (saw_head_reg && rx_byte == ffhtd_pkg::HEAD_SECOND)
                begin
                    collecting_next = 1'b1;
                    saw_head_next   = 1'b0;
                    tail_ok_next    = 1'b0;
                    byte_index_next = ffhtd_pkg::IDX_STORE_FIRST;
                end
                else
                begin
                    saw_head_next = (rx_byte == ffhtd_pkg::HEAD_FIRST);
                end
            end
            else if (byte_index_reg inside {[ffhtd_pkg::IDX_STORE_FIRST:
                                              ffhtd_pkg::IDX_STORE_LAST]})
            begin
                store_wr        = 1'b1;
                byte_index_next = byte_index_reg + 6'd1;
            end
            else if (byte_index_reg == ffhtd_pkg::IDX_TAIL_FIRST)
            begin
                tail_ok_next    = (rx_byte == ffhtd_pkg::TAIL_FIRST);
                byte_index_next = byte_index_reg + 6'd1;
            end
            else
            begin
                // End of frame, good or bad: back to hunting
                frame_good      = (byte_index_reg == ffhtd_pkg::IDX_TAIL_SECOND) &&
                                  tail_ok_reg && (rx_byte == ffhtd_pkg::TAIL_SECOND);
                collecting_next = 1'b0;
                saw_head_next   = 1'b0;
                tail_ok_next    = 1'b0;
                byte_index_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            collecting_reg <= 1'b0;
            saw_head_reg   <= 1'b0;
            tail_ok_reg    <= 1'b0;
            byte_index_reg <= '0;
        end
        else
        begin
            collecting_reg <= collecting_next;
            saw_head_reg   <= saw_head_next;
            tail_ok_reg    <= tail_ok_next;
            byte_index_reg <= byte_index_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (store_wr)
        begin
            store_reg[store_off[ffhtd_pkg::STORE_IDX_W-1:0]] <= rx_byte;
        end
    end

    assign status.frame_good  = frame_good;
    assign status.at_tail_end = collecting_reg &&
                                (byte_index_reg == ffhtd_pkg::IDX_TAIL_SECOND);

    // Little-endian fields, stored offsets relative to frame offset 2
    assign payload.aim_mode        = store_reg[0];
    assign payload.quat_w_bits     = {store_reg[4],  store_reg[3],  store_reg[2],  store_reg[1]};
    assign payload.quat_x_bits     = {store_reg[8],  store_reg[7],  store_reg[6],  store_reg[5]};
    assign payload.quat_y_bits     = {store_reg[12], store_reg[11], store_reg[10], store_reg[9]};
    assign payload.quat_z_bits     = {store_reg[16], store_reg[15], store_reg[14], store_reg[13]};
    assign payload.yaw_bits        = {store_reg[20], store_reg[19], store_reg[18], store_reg[17]};
    assign payload.yaw_rate_bits   = {store_reg[24], store_reg[23], store_reg[22], store_reg[21]};
    assign payload.pitch_bits      = {store_reg[28], store_reg[27], store_reg[26], store_reg[25]};
    assign payload.pitch_rate_bits = {store_reg[32], store_reg[31], store_reg[30], store_reg[29]};
    assign payload.shot_speed_bits = {store_reg[36], store_reg[35], store_reg[34], store_reg[33]};
    assign payload.shot_count      = {store_reg[38], store_reg[37]};

endmodule

// ===== hdl/ffhtd_out_reg.sv =====
// ----------------------------------------------------------------------------
// ffhtd_out_reg
// Result register holding one decoded frame until the sink takes it.
// ----------------------------------------------------------------------------
module ffhtd_out_reg
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          load,
    input  ffhtd_pkg::frame_payload_t     load_data,
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic [ffhtd_pkg::OUT_W-1:0]   out_data
);

    logic                          valid_reg;
    logic                          valid_next;
    logic [ffhtd_pkg::OUT_W-1:0]   data_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= load_data;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== hdl/fixed_frame_header_tail_deframer_core.sv =====
// ----------------------------------------------------------------------------
// fixed_frame_header_tail_deframer_core
// Hunts for the 5A A5 header, collects a 43-byte frame, checks the 7F FE
// tail and emits the decoded payload of each good frame.
// ----------------------------------------------------------------------------
//  channel   | direction | tdata                        | per item
//  s_axis    | in        | rx_byte [7:0]                | one received byte
//  m_axis    | out       | decoded frame [311:0]        | one good frame
//
//  One byte is taken per ready cycle; a good frame appears on m_axis the cycle
//  after its last tail byte is accepted, set by the single result register.
//  Reset clears the hunt/collect state and the result valid; stored bytes
//  are not cleared. Bytes keep flowing while a result waits; s_tready drops
//  only when the next byte could close a frame and the result is still held.
// ----------------------------------------------------------------------------
module fixed_frame_header_tail_deframer_core
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,  // [7:0] rx_byte
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [7:0] aim_mode, [39:8] quat_w_bits, [71:40] quat_x_bits,
    // [103:72] quat_y_bits, [135:104] quat_z_bits, [167:136] yaw_bits,
    // [199:168] yaw_rate_bits, [231:200] pitch_bits,
    // [263:232] pitch_rate_bits, [295:264] shot_speed_bits,
    // [311:296] shot_count
    output logic [ffhtd_pkg::OUT_W-1:0]   m_tdata
);

    logic                         byte_accept;
    ffhtd_pkg::framer_status_t    status;
    ffhtd_pkg::frame_payload_t    payload;

    // Hold input only when a closing byte would overwrite a waiting result
    assign s_tready    = !(status.at_tail_end && m_tvalid && !m_tready);
    assign byte_accept = s_tvalid && s_tready;

    ffhtd_framer u_framer
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_accept),
        .rx_byte    (s_tdata),
        .status     (status),
        .payload    (payload)
    );

    ffhtd_out_reg u_out_reg
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (status.frame_good),
        .load_data  (payload),
        .out_ready  (m_tready),
        .out_valid  (m_tvalid),
        .out_data   (m_tdata)
    );

endmodule

// ===== hdl/ffhtd_checker.sv =====
// ----------------------------------------------------------------------------
// ffhtd_checker
// Port-level checks of the deframer, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "fixed_frame_header_tail_deframer_core_defines.svh"

module ffhtd_checker
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [7:0]                    s_tdata,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [ffhtd_pkg::OUT_W-1:0]   m_tdata
);

    // A held result keeps its data
    `FFHTD_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // Input stalls only while a result is waiting
    `FFHTD_ASSERT_SAME(a_stall_cause, clk, rst_n, !s_tready, m_tvalid && !m_tready)

    // A new result follows an accepted byte
    `FFHTD_ASSERT_SAME(a_result_src, clk, rst_n, $rose(m_tvalid), $past(s_tvalid && s_tready))

    // A new result is closed by the second tail byte
    `FFHTD_ASSERT_SAME(a_result_tail, clk, rst_n, $rose(m_tvalid), $past(s_tdata) == ffhtd_pkg::TAIL_SECOND)

endmodule

bind fixed_frame_header_tail_deframer_core ffhtd_checker u_ffhtd_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== bench/tb_fixed_frame_header_tail_deframer_core.sv =====
// ----------------------------------------------------------------------------
// tb_fixed_frame_header_tail_deframer_core
// Drives byte streams into the deframer: clean frames, repeated and split
// headers, bad tails, sync patterns inside the payload and line noise. A
// tracker mirrors the hunt/collect behavior and checks every decoded frame,
// field by field, under random gaps on the byte side and stalls on the
// frame side.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_fixed_frame_header_tail_deframer_core;

    typedef enum int {TAIL_GOOD, TAIL_BAD_FIRST, TAIL_BAD_SECOND, TAIL_BAD_BOTH} tail_kind_t;
    typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES, FILL_SYNC} payload_fill_t;

    class deframe_tracker;
        ffhtd_pkg::frame_payload_t pending_frames[$];
        int unsigned    mismatch_count;
        bit             in_frame;
        bit             head_pending;
        logic [5:0]     frame_pos;
        bit             tail_ok;
        logic [7:0]     body[ffhtd_pkg::STORE_DEPTH];

        function new();
            mismatch_count = 0;
            in_frame       = 1'b0;
            head_pending   = 1'b0;
            frame_pos      = '0;
            tail_ok        = 1'b0;
            foreach (body[k]) body[k] = 8'h00;
        endfunction

        task flag_mismatch(string msg);
            mismatch_count++;
            $display("[%0t] mismatch: %s", $realtime, msg);
        endtask

        function logic [31:0] le32(int p);
            return {body[p+3], body[p+2], body[p+1], body[p]};
        endfunction

        // Advance the hunt/collect state by one accepted byte.
        function void take_byte(logic [7:0] b);
            ffhtd_pkg::frame_payload_t f;
            if (!in_frame) begin
                if (head_pending && b == ffhtd_pkg::HEAD_SECOND) begin
                    in_frame     = 1'b1;
                    head_pending = 1'b0;
                    frame_pos    = ffhtd_pkg::IDX_STORE_FIRST;
                    tail_ok      = 1'b0;
                end
                else begin
                    head_pending = (b == ffhtd_pkg::HEAD_FIRST);
                end
                return;
            end
            if (frame_pos <= ffhtd_pkg::IDX_STORE_LAST) begin
                body[frame_pos - ffhtd_pkg::IDX_STORE_FIRST] = b;
                frame_pos++;
            end
            else if (frame_pos == ffhtd_pkg::IDX_TAIL_FIRST) begin
                tail_ok = (b == ffhtd_pkg::TAIL_FIRST);
                frame_pos++;
            end
            else begin
                if (tail_ok && b == ffhtd_pkg::TAIL_SECOND) begin
                    f.aim_mode        = body[0];
                    f.quat_w_bits     = le32(1);
                    f.quat_x_bits     = le32(5);
                    f.quat_y_bits     = le32(9);
                    f.quat_z_bits     = le32(13);
                    f.yaw_bits        = le32(17);
                    f.yaw_rate_bits   = le32(21);
                    f.pitch_bits      = le32(25);
                    f.pitch_rate_bits = le32(29);
                    f.shot_speed_bits = le32(33);
                    f.shot_count      = {body[38], body[37]};
                    pending_frames.push_back(f);
                end
                // good or bad, the frame is consumed and hunting restarts
                in_frame     = 1'b0;
                head_pending = 1'b0;
                frame_pos    = '0;
                tail_ok      = 1'b0;
            end
        endfunction

        task check_field(string label, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                flag_mismatch($sformatf("%s got %h want %h", label, got, want));
        endtask

        task match_frame(ffhtd_pkg::frame_payload_t got);
            ffhtd_pkg::frame_payload_t want;
            if (pending_frames.size() == 0) begin
                flag_mismatch("decoded frame with none expected");
                return;
            end
            want = pending_frames.pop_front();
            check_field("aim_mode", 32'(got.aim_mode), 32'(want.aim_mode));
            check_field("quat_w_bits", got.quat_w_bits, want.quat_w_bits);
            check_field("quat_x_bits", got.quat_x_bits, want.quat_x_bits);
            check_field("quat_y_bits", got.quat_y_bits, want.quat_y_bits);
            check_field("quat_z_bits", got.quat_z_bits, want.quat_z_bits);
            check_field("yaw_bits", got.yaw_bits, want.yaw_bits);
            check_field("yaw_rate_bits", got.yaw_rate_bits, want.yaw_rate_bits);
            check_field("pitch_bits", got.pitch_bits, want.pitch_bits);
            check_field("pitch_rate_bits", got.pitch_rate_bits, want.pitch_rate_bits);
            check_field("shot_speed_bits", got.shot_speed_bits, want.shot_speed_bits);
            check_field("shot_count", 32'(got.shot_count), 32'(want.shot_count));
        endtask

        function int unsigned outstanding();
            return pending_frames.size();
        endfunction
    endclass

    logic                          clk      = 1'b0;
    logic                          rst_n    = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [7:0]                    s_tdata  = 8'h00;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [ffhtd_pkg::OUT_W-1:0]   m_tdata;

    deframe_tracker tracker = new();
    bit             burst_mode = 1'b0;
    int unsigned    bytes_sent = 0;

    fixed_frame_header_tail_deframer_core dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #1 clk = ~clk;

    initial
    begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n) begin
            if (m_tvalid && m_tready)
                tracker.match_frame(ffhtd_pkg::frame_payload_t'(m_tdata));
            if (s_tvalid && s_tready)
                tracker.take_byte(s_tdata);
        end
    end

    // Frame side: long ready stretches, short stalls, now and then a long one.
    initial
    begin
        int unsigned roll;
        @(posedge clk iff rst_n);
        forever begin
            roll = $urandom_range(0, 99);
            if (roll < 50) begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 30)) @(posedge clk);
            end
            else if (roll < 85) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge clk);
            end
            else if (roll < 95) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(5, 15)) @(posedge clk);
            end
            else begin
                m_tready <= 1'b0;
                repeat ($urandom_range(30, 80)) @(posedge clk);
            end
        end
    end

    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        if (roll < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // Hold the byte until the block takes it; tvalid stays high for the next one.
    task automatic send_byte(input logic [7:0] b);
        int unsigned gap;
        gap = burst_mode ? 0 : pick_gap();
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        bytes_sent++;
    endtask

    function automatic logic [7:0] payload_byte(payload_fill_t fill, int k);
        logic [7:0] sync_bytes[4];
        logic [7:0] corner[6];
        sync_bytes = '{ffhtd_pkg::HEAD_FIRST, ffhtd_pkg::HEAD_SECOND,
                       ffhtd_pkg::TAIL_FIRST, ffhtd_pkg::TAIL_SECOND};
        corner     = '{8'h00, 8'hFF, ffhtd_pkg::HEAD_FIRST, ffhtd_pkg::HEAD_SECOND,
                       ffhtd_pkg::TAIL_FIRST, ffhtd_pkg::TAIL_SECOND};
        case (fill)
            FILL_ZERO: return 8'h00;
            FILL_ONES: return 8'hFF;
            FILL_SYNC: return $urandom_range(0, 1) ? sync_bytes[k % 4] : 8'($urandom());
            default:   return ($urandom_range(0, 9) == 0) ? corner[$urandom_range(0, 5)]
                                                           : 8'($urandom());
        endcase
    endfunction

    function automatic logic [7:0] wrong_byte(logic [7:0] good);
        logic [7:0] b;
        b = 8'($urandom());
        if (b == good) b = ~good;
        return b;
    endfunction

    task automatic send_frame(input tail_kind_t tail, input payload_fill_t fill);
        send_byte(ffhtd_pkg::HEAD_FIRST);
        send_byte(ffhtd_pkg::HEAD_SECOND);
        for (int k = 0; k < ffhtd_pkg::STORE_DEPTH; k++)
            send_byte(payload_byte(fill, k));
        send_byte((tail == TAIL_BAD_FIRST || tail == TAIL_BAD_BOTH)
                  ? wrong_byte(ffhtd_pkg::TAIL_FIRST) : ffhtd_pkg::TAIL_FIRST);
        send_byte((tail == TAIL_BAD_SECOND || tail == TAIL_BAD_BOTH)
                  ? wrong_byte(ffhtd_pkg::TAIL_SECOND) : ffhtd_pkg::TAIL_SECOND);
    endtask

    // Drop tvalid and wait until every expected frame has come out.
    task automatic drain_frames();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (tracker.outstanding() != 0) @(posedge clk);
    endtask

    initial
    begin
        int unsigned roll;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Repeated first header byte, all-zero payload, back to back.
        burst_mode = 1'b1;
        send_byte(ffhtd_pkg::HEAD_FIRST);
        send_frame(TAIL_GOOD, FILL_ZERO);

        // Pending first header byte held across a long idle stretch.
        send_byte(8'h00);
        send_byte(ffhtd_pkg::HEAD_FIRST);
        s_tvalid <= 1'b0;
        repeat (25) @(posedge clk);
        send_byte(ffhtd_pkg::HEAD_SECOND);
        for (int k = 0; k < ffhtd_pkg::STORE_DEPTH; k++)
            send_byte(8'hFF);
        send_byte(ffhtd_pkg::TAIL_FIRST);
        send_byte(ffhtd_pkg::TAIL_SECOND);

        // Sync patterns inside a dropped frame must not resync; next frame is clean.
        burst_mode = 1'b0;
        send_frame(TAIL_BAD_SECOND, FILL_SYNC);
        send_frame(TAIL_GOOD, FILL_RANDOM);
        send_frame(TAIL_BAD_FIRST, FILL_SYNC);
        send_frame(TAIL_GOOD, FILL_SYNC);

        drain_frames();

        while (bytes_sent < 1450) begin
            burst_mode = ($urandom_range(0, 4) == 0);
            roll = $urandom_range(0, 99);
            if (roll < 60) begin
                if ($urandom_range(0, 4) == 0) send_byte(ffhtd_pkg::HEAD_FIRST);
                send_frame(TAIL_GOOD, FILL_RANDOM);
            end
            else if (roll < 70) begin
                send_frame(TAIL_GOOD, FILL_SYNC);
            end
            else if (roll < 80) begin
                send_frame(tail_kind_t'($urandom_range(1, 3)),
                           $urandom_range(0, 1) ? FILL_SYNC : FILL_RANDOM);
            end
            else if (roll < 97) begin
                // Line noise, heavy on header bytes to exercise false starts.
                repeat ($urandom_range(1, 8)) begin
                    case ($urandom_range(0, 3))
                        0:       send_byte(ffhtd_pkg::HEAD_FIRST);
                        1:       send_byte(ffhtd_pkg::HEAD_SECOND);
                        default: send_byte(8'($urandom()));
                    endcase
                end
            end
            else begin
                drain_frames();
            end
        end

        drain_frames();
        repeat (20) @(posedge clk);
        if (tracker.outstanding() != 0)
            tracker.flag_mismatch($sformatf("%0d expected frames never arrived",
                                            tracker.outstanding()));
        if (tracker.mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
